### hw/rtl/card_id_access_table_core_assert.svh
// Assertion macros shared by the card ID access table RTL.
`ifndef CARD_ID_ACCESS_TABLE_CORE_ASSERT_SVH
`define CARD_ID_ACCESS_TABLE_CORE_ASSERT_SVH

// A property that must hold on every clock edge out of reset.
`define CIDAT_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by another one on the next clock edge.
`define CIDAT_CHECK_NEXT(lbl, cause, effect, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);

`endif

### hw/rtl/cidat_pkg.sv
// Types and constants of the card ID access table.
package cidat_pkg;

	// Operation codes carried by an input beat.
	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_VALIDATE  = 3'd1,
		OP_REG_FIRST = 3'd2,
		OP_REG_NEXT  = 3'd3,
		OP_ARM       = 3'd4
	} opcode_t;

	// Registration modes for the arm operation.
	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_USER  = 2'd1,
		MODE_ADMIN = 2'd2
	} mode_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_EXEC,
		ST_DONE
	} state_t;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam logic [APB_ADDR_W-1:0] ADDR_INACT_LIMIT = 3'd0;
	localparam logic [31:0] INACT_LIMIT_RESET = 32'd30000;

	// Wide enough for any supported table size (up to 64 entries).
	localparam int COUNT_W = 7;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] card_id;
		logic [1:0]  mode;
	} in_item_t;

	typedef struct packed {
		logic ok;
		logic found;
		logic is_admin;
		logic is_allowed;
		logic is_first;
		logic timed_out;
	} out_item_t;

	// One stored table entry.
	typedef struct packed {
		logic [31:0] card_id;
		logic        admin;
		logic        allowed;
	} tbl_entry_t;

	// Status reported by the sequencer to the top level.
	typedef struct packed {
		logic               busy;
		logic               first_pending;
		logic [COUNT_W-1:0] user_count;
	} ctrl_status_t;

endpackage

### hw/rtl/cidat_stream_if.sv
// Valid/ready stream channel carrying one payload per beat.
interface cidat_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/cidat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cidat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/cidat_ctrl.sv
// Sequencer and session state of the card ID access table, with the shared ID comparator.
module cidat_ctrl #(
	parameter int MAX_USERS = 16,
	localparam int IDX_W = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1,
	localparam int CNT_W = $clog2(MAX_USERS + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	cidat_stream_if.sink             in_ch,
	cidat_stream_if.source           out_ch,
	input  logic [31:0]              inact_limit,
	output logic                     ram_we,
	output logic [IDX_W-1:0]         ram_waddr,
	output cidat_pkg::tbl_entry_t    ram_wdata,
	output logic [IDX_W-1:0]         ram_raddr,
	input  cidat_pkg::tbl_entry_t    ram_rdata,
	output cidat_pkg::ctrl_status_t  status
);

	cidat_pkg::state_t state_q, state_d;

	// Latched input beat.
	logic [2:0]  op_q;
	logic [31:0] id_q;
	logic [1:0]  mode_q;

	// Search progress.
	logic [CNT_W-1:0] idx_q;
	logic             hit_q;
	logic             hit_admin_q;
	logic             hit_allow_q;

	// Persistent table and session state.
	logic [CNT_W-1:0] count_q;
	logic [1:0]       pmode_q;
	logic             first_q;
	logic [31:0]      idle_q;
	logic             seen_q;
	logic             sess_admin_q;
	logic             sess_allow_q;
	logic             ok_q;
	logic             found_q;

	// Output register.
	logic                  out_vld_q;
	cidat_pkg::out_item_t  out_q;

	logic in_fire;
	logic out_load;
	logic id_match;
	logic last_entry;
	logic room;
	logic mode_armed;
	logic do_first;
	logic do_next;
	logic needs_search;

	assign in_fire      = in_ch.valid && in_ch.ready;
	assign id_match     = (ram_rdata.card_id == id_q);
	assign last_entry   = ((idx_q + CNT_W'(1)) == count_q);
	assign room         = (count_q < CNT_W'(MAX_USERS));
	assign mode_armed   = (pmode_q == cidat_pkg::MODE_USER) || (pmode_q == cidat_pkg::MODE_ADMIN);
	assign do_first     = (op_q == cidat_pkg::OP_REG_FIRST) && first_q && room;
	assign do_next      = (op_q == cidat_pkg::OP_REG_NEXT) && !hit_q && mode_armed && room;
	assign needs_search = ((in_ch.payload.opcode == cidat_pkg::OP_VALIDATE)
		|| (in_ch.payload.opcode == cidat_pkg::OP_REG_NEXT)) && (count_q != '0);

	// Table port: the read address follows the search index, appends go to the fill count.
	assign ram_raddr         = idx_q[IDX_W-1:0];
	assign ram_waddr         = count_q[IDX_W-1:0];
	assign ram_wdata.card_id = id_q;
	assign ram_wdata.admin   = do_first || (pmode_q == cidat_pkg::MODE_ADMIN);
	assign ram_wdata.allowed = 1'b1;

	assign out_ch.valid   = out_vld_q;
	assign out_ch.payload = out_q;

	assign status.busy          = (state_q != cidat_pkg::ST_IDLE);
	assign status.first_pending = first_q;
	assign status.user_count    = cidat_pkg::COUNT_W'(count_q);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cidat_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		ram_we      = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			cidat_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = needs_search ? cidat_pkg::ST_READ : cidat_pkg::ST_EXEC;
				end
			end
			cidat_pkg::ST_READ: begin
				state_d = cidat_pkg::ST_CMP;
			end
			cidat_pkg::ST_CMP: begin
				state_d = (id_match || last_entry) ? cidat_pkg::ST_EXEC : cidat_pkg::ST_READ;
			end
			cidat_pkg::ST_EXEC: begin
				ram_we  = do_first || do_next;
				state_d = cidat_pkg::ST_DONE;
			end
			cidat_pkg::ST_DONE: begin
				if (!out_vld_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = cidat_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cidat_pkg::ST_IDLE;
			end
		endcase
	end

	// Latch the beat and walk the stored entries.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= in_ch.payload.opcode;
			id_q   <= in_ch.payload.card_id;
			mode_q <= in_ch.payload.mode;
			idx_q  <= '0;
		end else if (state_q == cidat_pkg::ST_CMP && !id_match) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (state_q == cidat_pkg::ST_CMP && id_match) begin
			hit_admin_q <= ram_rdata.admin;
			hit_allow_q <= ram_rdata.allowed;
		end
	end

	// Hit flag is control: it steers the execute step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (in_fire) begin
			hit_q <= 1'b0;
		end else if (state_q == cidat_pkg::ST_CMP && id_match) begin
			hit_q <= 1'b1;
		end
	end

	// Execute step: update the table and session state for the latched operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			pmode_q      <= cidat_pkg::MODE_NONE;
			first_q      <= 1'b1;
			idle_q       <= '0;
			seen_q       <= 1'b0;
			sess_admin_q <= 1'b0;
			sess_allow_q <= 1'b0;
			ok_q         <= 1'b0;
			found_q      <= 1'b0;
		end else if (state_q == cidat_pkg::ST_EXEC) begin
			ok_q    <= 1'b0;
			found_q <= 1'b0;
			case (op_q)
				cidat_pkg::OP_TICK: begin
					if (idle_q != '1) begin
						idle_q <= idle_q + 32'd1;
					end
					ok_q <= 1'b1;
				end
				cidat_pkg::OP_VALIDATE: begin
					seen_q       <= 1'b1;
					sess_admin_q <= hit_q && hit_admin_q;
					sess_allow_q <= hit_q && hit_allow_q;
					found_q      <= hit_q;
					ok_q         <= hit_q;
					if (hit_q) begin
						idle_q <= '0;
					end
				end
				cidat_pkg::OP_REG_FIRST: begin
					if (do_first) begin
						count_q      <= count_q + CNT_W'(1);
						first_q      <= 1'b0;
						seen_q       <= 1'b1;
						sess_admin_q <= 1'b1;
						sess_allow_q <= 1'b1;
						idle_q       <= '0;
						ok_q         <= 1'b1;
					end
				end
				cidat_pkg::OP_REG_NEXT: begin
					seen_q  <= 1'b1;
					found_q <= hit_q;
					if (do_next) begin
						count_q <= count_q + CNT_W'(1);
						pmode_q <= cidat_pkg::MODE_NONE;
						idle_q  <= '0;
						ok_q    <= 1'b1;
					end
				end
				cidat_pkg::OP_ARM: begin
					// The unused mode code arms nothing.
					pmode_q <= (mode_q == 2'd3) ? cidat_pkg::MODE_NONE : mode_q;
					ok_q    <= 1'b1;
				end
				default: begin
					ok_q <= 1'b0;
				end
			endcase
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Result payload, with the time-out judged on the updated state.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.ok         <= ok_q;
			out_q.found      <= found_q;
			out_q.is_admin   <= sess_admin_q;
			out_q.is_allowed <= sess_allow_q;
			out_q.is_first   <= first_q;
			out_q.timed_out  <= (idle_q >= inact_limit) || !seen_q;
		end
	end

endmodule

### hw/rtl/card_id_access_table_core.sv
// Top level of the card ID access table: configuration port, table RAM and sequencer.
//
// Keeps up to MAX_USERS card IDs with admin and allowed marks and runs one operation per
// input beat (tick, validate, register first, register next, arm), returning one result
// beat with ok, found, the session flags, the first-admin flag and the time-out flag. The
// block takes one operation at a time. Tick, arm and register first go from acceptance
// through an execute state and a done state, where the result is loaded once the output
// is free; validate and register next first search the stored entries through the
// single read port of the table RAM, with a read state and a compare state for each
// entry examined, up to user_count. The next beat is accepted in the cycle after the result
// is loaded, even while that result still waits at the output. The table needs no clearing
// after reset, as only filled entries are ever searched. The idle limit register lies at
// address 0 and should be written only while the block is idle.
module card_id_access_table_core #(
	parameter int MAX_USERS = 16,
	localparam int IDX_W = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	cidat_stream_if.sink                       in_ch,
	cidat_stream_if.source                     out_ch,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cidat_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	logic [31:0]             inact_limit_q;
	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [IDX_W-1:0]        ram_raddr;
	cidat_pkg::tbl_entry_t   ram_wdata;
	cidat_pkg::tbl_entry_t   ram_rdata;
	cidat_pkg::ctrl_status_t status;

	// Configuration register: written in the access phase of an APB write.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inact_limit_q <= cidat_pkg::INACT_LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr == cidat_pkg::ADDR_INACT_LIMIT) begin
			inact_limit_q <= pwdata;
		end
	end

	assign prdata = (paddr == cidat_pkg::ADDR_INACT_LIMIT) ? inact_limit_q : 32'd0;

	// Card table storage.
	cidat_ram #(
		.WIDTH ($bits(cidat_pkg::tbl_entry_t)),
		.DEPTH (MAX_USERS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Operation sequencer.
	cidat_ctrl #(
		.MAX_USERS (MAX_USERS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.inact_limit (inact_limit_q),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.status      (status)
	);

	// Design checks.
`include "card_id_access_table_core_assert.svh"

	`CIDAT_CHECK(a_count_bound, status.user_count <= cidat_pkg::COUNT_W'(MAX_USERS), "user count beyond table size")
	`CIDAT_CHECK(a_append_room, !ram_we || status.user_count < cidat_pkg::COUNT_W'(MAX_USERS), "append into a full table")
	`CIDAT_CHECK(a_first_admin, status.first_pending || status.user_count != '0, "bootstrap admin missing from table")
	`CIDAT_CHECK_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, status.busy, "sequencer idle after accepting a beat")

endmodule
